[sv/ttsb_pkg.sv]
`default_nettype none
package ttsb_pkg;

    // Texel inputs per item and band limits
    localparam int TEXEL_INPUTS  = 4;
    localparam int MAX_BANDS_DEF = 4;

    // Fixed-point constants (heights Q8.8, normal Q1.14, weights Q1.8)
    localparam int NOISE_BASE     = 52429;  // 0.8 in Q.16
    localparam int STRIP_Q8       = 7680;   // 30.0 in Q.8
    localparam int BLEND_START    = 3072;   // 0.4 of a strip
    localparam int SHORE_LOW      = 896;    // 3.5 in Q.8
    localparam int SHORE_HIGH     = 1408;   // 5.5 in Q.8
    localparam int NU_STEEP       = 8192;   // 0.5 in Q1.14
    localparam int NU_SLOPE_MAX   = 13107;  // last code not above 0.8
    localparam int NU_SHORE_FULL  = 14746;  // first code above 0.9
    localparam int SLOPE_FADE_OFS = 40960;  // 5 * 0.5
    localparam int SHORE_FADE_OFS = 65536;  // 5 * 0.8
    localparam int RECIP_18       = 3641;   // ceil(2^16 / 18)
    localparam int RECIP_3        = 683;    // ceil(2^11 / 3)
    localparam int WEIGHT_ONE     = 256;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register indexes
    localparam logic [1:0] REG_BAND_COUNT  = 2'd0;
    localparam logic [1:0] REG_NOISE_GAIN  = 2'd1;
    localparam logic [1:0] REG_GREY_MASK   = 2'd2;

    typedef struct packed {
        logic [2:0]  band_count;
        logic [15:0] noise_gain;
        logic [5:0]  grey_source_mask;
    } cfg_t;

    typedef struct packed {
        logic [15:0] terrain_height;
        logic [15:0] mirrored_height;
        logic [14:0] normal_up;
        logic [23:0] band_texel_0;
        logic [23:0] band_texel_1;
        logic [23:0] band_texel_2;
        logic [23:0] band_texel_3;
        logic [23:0] slope_texel;
        logic [23:0] shore_texel;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] band_index;
    } result_t;

    typedef enum logic [2:0] {
        MODE_PLAIN,
        MODE_STEEP,
        MODE_SLOPE_FADE,
        MODE_SHORE_FULL,
        MODE_SHORE_FADE
    } mode_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic [1:0]        band_index;
        logic              blend;
        logic [12:0]       excess;
        mode_t             mode;
        logic [14:0]       fade_num;
        logic [3:0][23:0]  band_texels;
        logic [23:0]       slope_texel;
        logic [23:0]       shore_texel;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

[sv/terrain_texture_splat_blend_unit.sv]
`default_nettype none
// Terrain texture splat blender: takes one pixel item per clock (start high,
// busy low) and returns one RGB result with its band index. The result is
// driven on result for exactly one cycle with done high; the receiver cannot
// stall it. Throughput is one item per cycle while busy is low, set by the
// pipeline: three front stages (noise multiply, height multiply, band and
// normal classification), one queue register, and four back stages (weight
// reciprocals, weight scaling and texel select, channel products, sums).
// busy rises only if the front-to-back queue fills, and the back end drains it
// every cycle. Configuration (band_count, noise_gain, grey_source_mask at
// indexes 0 to 2) is to be written by the user through cfg_we only while no
// item is in flight; the block itself does not enforce this.
module terrain_texture_splat_blend_unit #(
    parameter int MAX_BANDS = ttsb_pkg::MAX_BANDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ttsb_pkg::in_item_t item,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               done,
    output ttsb_pkg::result_t  result
);
    import ttsb_pkg::*;

    localparam int BAND_LIMIT = (MAX_BANDS < TEXEL_INPUTS) ? MAX_BANDS : TEXEL_INPUTS;

    cfg_t       cfg_reg;
    logic [2:0] band_limit;
    logic       take;
    logic       push;
    logic       pop;
    job_t       front_job;
    job_t       q_data;
    q_status_t  q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_count       <= 3'd4;
            cfg_reg.noise_gain       <= 16'd874;
            cfg_reg.grey_source_mask <= 6'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BAND_COUNT: cfg_reg.band_count       <= cfg_data[2:0];
                REG_NOISE_GAIN: cfg_reg.noise_gain       <= cfg_data;
                REG_GREY_MASK:  cfg_reg.grey_source_mask <= cfg_data[5:0];
                default:        cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Clamp band count to 1 .. limit
    always_comb
    begin
        if (cfg_reg.band_count == 3'd0)
            band_limit = 3'd1;
        else if (cfg_reg.band_count > 3'(BAND_LIMIT))
            band_limit = 3'(BAND_LIMIT);
        else
            band_limit = cfg_reg.band_count;
    end

    assign busy = q_stat.full;
    assign take = start && !busy;

    ttsb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .item       (item),
        .cfg        (cfg_reg),
        .band_limit (band_limit),
        .hold       (q_stat.full),
        .push       (push),
        .job        (front_job)
    );

    ttsb_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .din    (front_job),
        .pop    (pop),
        .dout   (q_data),
        .status (q_stat)
    );

    ttsb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_stat.empty),
        .q_data  (q_data),
        .cfg     (cfg_reg),
        .pop     (pop),
        .done    (done),
        .result  (result)
    );

    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##8 done)
        else $error("accepted item produced no result at fixed latency");

    a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 8))
        else $error("result without a matching accepted item");

    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !q_stat.full)
        else $error("front-to-back queue filled");

    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, result.band_index} < band_limit))
        else $error("band index beyond active band count");

endmodule
`default_nettype wire

[sv/ttsb_front.sv]
`default_nettype none
module ttsb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  ttsb_pkg::in_item_t item,
    input  ttsb_pkg::cfg_t    cfg,
    input  logic [2:0]        band_limit,
    input  logic              hold,
    output logic              push,
    output ttsb_pkg::job_t    job
);
    import ttsb_pkg::*;

    logic        s1_valid_reg;
    in_item_t    s1_item_reg;
    logic [31:0] gm_reg;

    logic        s2_valid_reg;
    in_item_t    s2_item_reg;
    logic [40:0] hf_reg;

    logic        s3_valid_reg;
    job_t        job_reg;

    logic [24:0] factor;
    logic [40:0] hf_next;
    job_t        job_next;

    // Stage 2: noise factor and scaled height product
    always_comb
    begin
        factor  = 25'(NOISE_BASE) + {1'b0, gm_reg[31:8]};
        hf_next = 41'(s1_item_reg.terrain_height) * 41'(factor);
    end

    // Stage 3: band choice and normal classification
    always_comb
    begin
        logic [24:0] hs;
        logic        beyond;
        logic [15:0] num;
        logic [1:0]  idx;
        logic [12:0] rem;
        logic [1:0]  last;
        logic [17:0] five_nu;
        logic [14:0] nu;
        logic        shore_band;

        hs      = hf_reg[40:16];
        beyond  = hs >= 25'(STRIP_Q8);
        num     = 16'(hs[12:0]) * 16'(band_limit);
        last    = 2'(band_limit - 3'd1);
        nu      = s2_item_reg.normal_up;
        five_nu = {1'b0, nu, 2'b00} + {3'b000, nu};
        shore_band = (hs > 25'(SHORE_LOW)) && (hs < 25'(SHORE_HIGH));

        if (num >= 16'(3 * STRIP_Q8))
        begin
            idx = 2'd3;
            rem = 13'(num - 16'(3 * STRIP_Q8));
        end
        else if (num >= 16'(2 * STRIP_Q8))
        begin
            idx = 2'd2;
            rem = 13'(num - 16'(2 * STRIP_Q8));
        end
        else if (num >= 16'(STRIP_Q8))
        begin
            idx = 2'd1;
            rem = 13'(num - 16'(STRIP_Q8));
        end
        else
        begin
            idx = 2'd0;
            rem = num[12:0];
        end

        job_next = '0;
        job_next.excess = rem - 13'(BLEND_START);
        if (beyond)
        begin
            job_next.band_index = last;
            job_next.blend      = 1'b0;
        end
        else
        begin
            job_next.band_index = idx;
            job_next.blend      = (idx < last) && (rem > 13'(BLEND_START));
        end

        if (nu <= 15'(NU_SLOPE_MAX))
        begin
            job_next.fade_num = 15'(five_nu - 18'(SLOPE_FADE_OFS));
            if (nu < 15'(NU_STEEP))
                job_next.mode = MODE_STEEP;
            else
                job_next.mode = MODE_SLOPE_FADE;
        end
        else if (shore_band)
        begin
            job_next.fade_num = 15'(five_nu - 18'(SHORE_FADE_OFS));
            if (nu >= 15'(NU_SHORE_FULL))
                job_next.mode = MODE_SHORE_FULL;
            else
                job_next.mode = MODE_SHORE_FADE;
        end
        else
        begin
            job_next.fade_num = '0;
            job_next.mode     = MODE_PLAIN;
        end

        job_next.band_texels = {s2_item_reg.band_texel_3, s2_item_reg.band_texel_2,
                                s2_item_reg.band_texel_1, s2_item_reg.band_texel_0};
        job_next.slope_texel = s2_item_reg.slope_texel;
        job_next.shore_texel = s2_item_reg.shore_texel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            s1_item_reg <= item;
            gm_reg      <= 32'(item.mirrored_height) * 32'(cfg.noise_gain);
            s2_item_reg <= s1_item_reg;
            hf_reg      <= hf_next;
            job_reg     <= job_next;
        end
    end

    assign push = s3_valid_reg && !hold;
    assign job  = job_reg;

endmodule
`default_nettype wire

[sv/ttsb_queue.sv]
`default_nettype none
module ttsb_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ttsb_pkg::job_t       din,
    input  logic                 pop,
    output ttsb_pkg::job_t       dout,
    output ttsb_pkg::q_status_t  status
);
    import ttsb_pkg::*;

    job_t                 entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign status.full  = count_reg == Q_CNT_W'(Q_DEPTH);
    assign status.empty = count_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign dout         = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

[sv/ttsb_back.sv]
`default_nettype none
module ttsb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  ttsb_pkg::job_t      q_data,
    input  ttsb_pkg::cfg_t      cfg,
    output logic                pop,
    output logic                done,
    output ttsb_pkg::result_t   result
);
    import ttsb_pkg::*;

    function automatic logic [23:0] greyed(input logic [23:0] texel, input logic grey);
        logic [7:0] r;
        r = texel[23:16];
        return grey ? {r, r, r} : texel;
    endfunction

    // Stage 1: band blend weight and fade ratio
    logic        b1_valid_reg;
    job_t        b1_job_reg;
    logic [7:0]  w2_reg;
    logic [7:0]  r_reg;
    logic [24:0] w2_prod;
    logic [19:0] r_prod;

    // Stage 2: final weights and sources
    logic             b2_valid_reg;
    logic [1:0]       b2_idx_reg;
    logic [3:0][23:0] src_reg;
    logic [3:0][8:0]  wt_reg;
    logic [3:0][23:0] src_next;
    logic [3:0][8:0]  wt_next;

    // Stage 3: channel terms
    logic                 b3_valid_reg;
    logic [1:0]           b3_idx_reg;
    logic [3:0][2:0][7:0] term_reg;
    logic [3:0][2:0][7:0] term_next;

    // Stage 4: sums
    logic     done_reg;
    result_t  result_reg;
    result_t  result_next;

    assign pop = !q_empty;

    always_comb
    begin
        w2_prod = 25'(q_data.excess) * 25'(RECIP_18);
        r_prod  = 20'(q_data.fade_num[14:5]) * 20'(RECIP_3);
    end

    always_comb
    begin
        logic [8:0]  w1;
        logic [8:0]  w2;
        logic [8:0]  side;
        logic [16:0] sc1;
        logic [16:0] sc2;
        logic [1:0]  idx;
        logic [1:0]  idx_up;

        w1   = 9'(WEIGHT_ONE) - {1'b0, w2_reg};
        w2   = {1'b0, w2_reg};
        side = 9'(WEIGHT_ONE) - {1'b0, r_reg};
        sc1  = 17'(w1) * 17'(r_reg);
        sc2  = 17'(w2) * 17'(r_reg);

        case (b1_job_reg.mode)
            MODE_STEEP:
                wt_next = {9'd0, 9'(WEIGHT_ONE), 9'd0, 9'd0};
            MODE_SLOPE_FADE:
                wt_next = {9'd0, side, sc2[16:8], sc1[16:8]};
            MODE_SHORE_FULL:
                wt_next = {9'(WEIGHT_ONE), 9'd0, 9'd0, 9'd0};
            MODE_SHORE_FADE:
                wt_next = {side, 9'd0, sc2[16:8], sc1[16:8]};
            default:
                wt_next = {9'd0, 9'd0, w2, w1};
        endcase

        idx    = b1_job_reg.band_index;
        idx_up = idx + 2'd1;
        src_next[0] = greyed(b1_job_reg.band_texels[idx],
                             cfg.grey_source_mask[{1'b0, idx}]);
        src_next[1] = greyed(b1_job_reg.band_texels[idx_up],
                             cfg.grey_source_mask[{1'b0, idx_up}]);
        src_next[2] = greyed(b1_job_reg.slope_texel, cfg.grey_source_mask[4]);
        src_next[3] = greyed(b1_job_reg.shore_texel, cfg.grey_source_mask[5]);
    end

    always_comb
    begin
        logic [16:0] p;
        for (int s = 0; s < 4; s++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                p = 17'(src_reg[s][c*8 +: 8]) * 17'(wt_reg[s]);
                term_next[s][c] = p[15:8];
            end
        end
    end

    always_comb
    begin
        logic [2:0][7:0] sum;
        for (int c = 0; c < 3; c++)
            sum[c] = term_reg[0][c] + term_reg[1][c] + term_reg[2][c] + term_reg[3][c];
        result_next.red        = sum[2];
        result_next.green      = sum[1];
        result_next.blue       = sum[0];
        result_next.band_index = b3_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= pop;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            done_reg     <= b3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_job_reg <= q_data;
        w2_reg     <= q_data.blend ? w2_prod[23:16] : 8'd0;
        r_reg      <= r_prod[18:11];
        b2_idx_reg <= b1_job_reg.band_index;
        src_reg    <= src_next;
        wt_reg     <= wt_next;
        b3_idx_reg <= b2_idx_reg;
        term_reg   <= term_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

[dv/splat_blend_checker.sv]
`timescale 1ns / 100ps

module splat_blend_checker
    import ttsb_pkg::*;
#(
    parameter int MAX_BANDS = MAX_BANDS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  in_item_t   item,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data,
    input  logic       done,
    input  result_t    result,
    output int         fail_count,
    output int         pending
);

    localparam int BAND_LIMIT = (MAX_BANDS < TEXEL_INPUTS) ? MAX_BANDS : TEXEL_INPUTS;
    localparam int BLEND_SPAN = 4608;

    logic [2:0]  cfg_bands;
    logic [15:0] cfg_gain;
    logic [5:0]  cfg_grey;

    result_t expected_pixels [$];

    // Add one weighted texel to the running RGB sums, each channel wrapping at a byte
    function automatic logic [23:0] mix_in(logic [23:0] acc, logic [23:0] tex, logic grey,
                                           int unsigned w);
        int unsigned c [3];
        logic [23:0] sum;
        c[0] = 32'(tex[23:16]);
        c[1] = grey ? c[0] : 32'(tex[15:8]);
        c[2] = grey ? c[0] : 32'(tex[7:0]);
        sum[23:16] = acc[23:16] + 8'((c[0] * w) >> 8);
        sum[15:8]  = acc[15:8] + 8'((c[1] * w) >> 8);
        sum[7:0]   = acc[7:0] + 8'((c[2] * w) >> 8);
        return sum;
    endfunction

    function automatic result_t blend_pixel(in_item_t px);
        logic [63:0] n, f, hs, num, idx, rem, r, nu;
        int unsigned w1, w2, side_w, shore_w;
        logic [1:0] sel, sel_up;
        logic [23:0] acc;
        logic [23:0] band_tex [4];
        result_t res;
        band_tex[0] = px.band_texel_0;
        band_tex[1] = px.band_texel_1;
        band_tex[2] = px.band_texel_2;
        band_tex[3] = px.band_texel_3;
        w1 = WEIGHT_ONE;
        w2 = 0;
        side_w = 0;
        shore_w = 0;
        acc = '0;

        n = 64'(cfg_bands);
        if (n == 0) n = 64'd1;
        if (n > BAND_LIMIT) n = 64'(BAND_LIMIT);

        f   = NOISE_BASE + ((64'(px.mirrored_height) * cfg_gain) >> 8);
        hs  = (64'(px.terrain_height) * f) >> 16;
        num = hs * n;
        idx = num / STRIP_Q8;
        rem = num % STRIP_Q8;

        // clamp to the top band, or fade toward the next one over the upper strip
        if (idx >= n) begin
            idx = n - 1;
        end else if (idx < n - 1 && rem > BLEND_START) begin
            w2 = 32'(((rem - BLEND_START) * 256) / BLEND_SPAN);
            w1 = WEIGHT_ONE - w2;
        end

        nu = 64'(px.normal_up);
        if (nu * 5 < 65536) begin
            if (nu < NU_STEEP) begin
                side_w = WEIGHT_ONE;
                w1 = 0;
                w2 = 0;
            end else begin
                r = (5 * (nu - NU_STEEP)) / 96;
                side_w = WEIGHT_ONE - 32'(r);
                w1 = 32'((w1 * r) >> 8);
                w2 = 32'((w2 * r) >> 8);
            end
        end else if (nu * 5 > 65536 && hs > SHORE_LOW && hs < SHORE_HIGH) begin
            if (nu * 10 > 147456) begin
                shore_w = WEIGHT_ONE;
                w1 = 0;
                w2 = 0;
            end else begin
                r = (5 * nu - 65536) / 96;
                shore_w = WEIGHT_ONE - 32'(r);
                w1 = 32'((w1 * r) >> 8);
                w2 = 32'((w2 * r) >> 8);
            end
        end

        sel    = idx[1:0];
        sel_up = sel + 2'd1;
        acc = mix_in(acc, band_tex[sel], cfg_grey[{1'b0, sel}], w1);
        if (w2 > 0 && idx + 1 < n)
            acc = mix_in(acc, band_tex[sel_up], cfg_grey[{1'b0, sel_up}], w2);
        if (side_w > 0)
            acc = mix_in(acc, px.slope_texel, cfg_grey[4], side_w);
        if (shore_w > 0)
            acc = mix_in(acc, px.shore_texel, cfg_grey[5], shore_w);

        res.red        = acc[23:16];
        res.green      = acc[15:8];
        res.blue       = acc[7:0];
        res.band_index = idx[1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        result_t want;
        bit bad;
        if (!rst_n) begin
            cfg_bands = 3'd4;
            cfg_gain  = 16'd874;
            cfg_grey  = 6'd0;
            expected_pixels.delete();
            fail_count <= 0;
            pending    <= 0;
        end else begin
            bad = 1'b0;
            if (cfg_we) begin
                case (cfg_index)
                    REG_BAND_COUNT: cfg_bands = cfg_data[2:0];
                    REG_NOISE_GAIN: cfg_gain  = cfg_data;
                    REG_GREY_MASK:  cfg_grey  = cfg_data[5:0];
                    default: ;
                endcase
            end
            // compare before queuing: a result never belongs to the item taken this edge
            if (done) begin
                if (expected_pixels.size() == 0) begin
                    $error("result with no item outstanding: %h", result);
                    bad = 1'b1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (result.red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, result.red);
                        bad = 1'b1;
                    end
                    if (result.green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, result.green);
                        bad = 1'b1;
                    end
                    if (result.blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, result.blue);
                        bad = 1'b1;
                    end
                    if (result.band_index !== want.band_index) begin
                        $error("band_index: expected %0d, got %0d", want.band_index,
                               result.band_index);
                        bad = 1'b1;
                    end
                end
            end
            if (start && !busy)
                expected_pixels.insert(expected_pixels.size(), blend_pixel(item));
            if (bad)
                fail_count <= fail_count + 1;
            pending <= expected_pixels.size();
        end
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
    import ttsb_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 1000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    pixel;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        done;
    result_t     blended;
    int          fail_count;
    int          pending;
    int          stall_cycles;

    terrain_texture_splat_blend_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (pixel),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (blended)
    );

    splat_blend_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (pixel),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .result     (blended),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic in_item_t make_pixel(logic [15:0] h, logic [15:0] m, logic [14:0] nu);
        in_item_t px;
        px.terrain_height  = h;
        px.mirrored_height = m;
        px.normal_up       = nu;
        px.band_texel_0    = 24'($urandom);
        px.band_texel_1    = 24'($urandom);
        px.band_texel_2    = 24'($urandom);
        px.band_texel_3    = 24'($urandom);
        px.slope_texel     = 24'($urandom);
        px.shore_texel     = 24'($urandom);
        return px;
    endfunction

    // Bias heights toward the band strips and the shore zone, normals toward each regime
    function automatic in_item_t random_pixel();
        logic [15:0] h, m;
        logic [14:0] nu;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: h = 16'($urandom_range(0, 12000));
            4, 5:       h = 16'($urandom_range(1000, 1900));
            default:    h = 16'($urandom);
        endcase
        m = $urandom_range(0, 1) ? 16'($urandom_range(0, 2000)) : 16'($urandom);
        case ($urandom_range(0, 5))
            0:       nu = 15'($urandom_range(0, 8191));
            1:       nu = 15'($urandom_range(8192, 13107));
            2:       nu = 15'($urandom_range(13108, 14746));
            3:       nu = 15'($urandom_range(14746, 16384));
            default: nu = 15'($urandom);
        endcase
        return make_pixel(h, m, nu);
    endfunction

    task automatic send_pixel(input in_item_t px);
        @(negedge clk);
        start <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic hold_off(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [2:0] bands, input logic [15:0] gain,
                             input logic [5:0] mask, input int count, input bit with_gaps);
        logic [15:0] junk;
        bit gaps_on;
        drain();
        junk = 16'($urandom);
        write_reg(REG_BAND_COUNT, {junk[15:3], bands});
        write_reg(REG_NOISE_GAIN, gain);
        junk = 16'($urandom);
        write_reg(REG_GREY_MASK, {junk[15:6], mask});
        gaps_on = 1'b0;
        for (int i = 0; i < count; i++) begin
            // pick per stretch whether the sender pauses
            if (i % 30 == 0)
                gaps_on = with_gaps && ($urandom_range(0, 2) != 0);
            if (gaps_on && $urandom_range(0, 4) == 0)
                hold_off($urandom_range(1, 18));
            send_pixel(random_pixel());
        end
    endtask

    initial begin
        in_item_t px;
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        pixel     = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed items at the reset settings
        px = make_pixel(16'd0, 16'd0, 15'd16384);
        px.band_texel_0 = 24'hFFFFFF;
        px.slope_texel  = 24'hFFFFFF;
        px.shore_texel  = 24'hFFFFFF;
        send_pixel(px);
        px = make_pixel(16'hFFFF, 16'hFFFF, 15'd16384);
        px.band_texel_3 = 24'h000000;
        send_pixel(px);
        px = make_pixel(16'hFFFF, 16'd0, 15'd0);
        px.band_texel_0 = 24'hFFFFFF;
        px.band_texel_1 = 24'hFFFFFF;
        px.band_texel_2 = 24'hFFFFFF;
        px.band_texel_3 = 24'hFFFFFF;
        px.slope_texel  = 24'hFFFFFF;
        px.shore_texel  = 24'hFFFFFF;
        send_pixel(px);
        px = make_pixel(16'd1440, 16'd0, 15'h7FFF);
        px.band_texel_0 = 24'h000000;
        px.band_texel_1 = 24'h000000;
        px.band_texel_2 = 24'h000000;
        px.band_texel_3 = 24'h000000;
        px.slope_texel  = 24'h000000;
        px.shore_texel  = 24'h000000;
        send_pixel(px);
        // normal thresholds inside the shore zone
        send_pixel(make_pixel(16'd1440, 16'd0, 15'd8191));
        send_pixel(make_pixel(16'd1440, 16'd0, 15'd8192));
        send_pixel(make_pixel(16'd1440, 16'd0, 15'd13107));
        send_pixel(make_pixel(16'd1440, 16'd0, 15'd13108));
        send_pixel(make_pixel(16'd1440, 16'd0, 15'd14745));
        send_pixel(make_pixel(16'd1440, 16'd0, 15'd14746));
        send_pixel(make_pixel(16'd1440, 16'd0, 15'd16384));
        send_pixel(make_pixel(16'd1440, 16'd0, 15'd16385));
        // shore zone edges, both excluded
        send_pixel(make_pixel(16'd1120, 16'd0, 15'd16384));
        send_pixel(make_pixel(16'd1760, 16'd0, 15'd16384));
        send_pixel(make_pixel(16'd1440, 16'd0, 15'd14000));
        // band fade, plain and faded by slope
        send_pixel(make_pixel(16'd1875, 16'd0, 15'd16384));
        send_pixel(make_pixel(16'd1875, 16'd0, 15'd10000));
        send_pixel(make_pixel(16'd9000, 16'd500, 15'd16384));
        send_pixel(make_pixel(16'd6000, 16'hFFFF, 15'd12000));
        send_pixel(make_pixel(16'd30000, 16'd0, 15'd16384));

        run_phase(3'd4, 16'd874, 6'd0, 88, 1'b1);
        run_phase(3'd1, 16'd874, 6'h3F, 88, 1'b1);
        run_phase(3'd2, 16'd0, 6'h15, 88, 1'b1);
        run_phase(3'd3, 16'hFFFF, 6'h2A, 88, 1'b1);
        drain();
        write_reg(REG_SPARE, 16'($urandom));
        run_phase(3'd0, 16'd874, 6'($urandom), 88, 1'b1);
        run_phase(3'd7, 16'($urandom), 6'h3F, 88, 1'b1);
        run_phase(3'd5, 16'd300, 6'($urandom), 88, 1'b1);
        run_phase(3'd4, 16'd874, 6'd0, 88, 1'b0);

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
